// ===== design/multi_bus_volume_fader_macros.svh =====
// Assertion macros shared by the fader modules.
`ifndef MULTI_BUS_VOLUME_FADER_MACROS_SVH
`define MULTI_BUS_VOLUME_FADER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MBVF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mbvf_pkg.sv =====
// Shared widths, opcodes, reset defaults and divider status type for the fader.
package mbvf_pkg;

  localparam int NUM_BUSES = 6;
  localparam int BUS_W     = 3;
  localparam int IDX_W     = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
  localparam int SCAN_W    = $clog2(NUM_BUSES + 1);
  localparam int VOL_W     = 16;
  localparam int LEN_W     = 16;
  localparam int ELA_W     = 17;
  localparam int DT_W      = 8;
  localparam int DIVD_W    = 24;
  localparam int DIVS_W    = 17;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  localparam logic [1:0] OP_SET_VOL  = 2'd0;
  localparam logic [1:0] OP_FADE     = 2'd1;
  localparam logic [1:0] OP_SET_MUTE = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  localparam logic [VOL_W-1:0] UNITY_Q14 = 16'd16384;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Reset volume of each bus in Q2.14; buses past the fourth start at unity.
  function automatic logic [VOL_W-1:0] default_volume(input int idx);
    logic [VOL_W-1:0] v;
    case (idx)
      0:       v = 16'd13926;
      1:       v = 16'd9830;
      2:       v = 16'd13107;
      3:       v = 16'd11469;
      default: v = UNITY_Q14;
    endcase
    return v;
  endfunction

endpackage

// ===== design/multi_bus_volume_fader.sv =====
// Top level: per-bus volume, fade and mute state with a sequenced fade update.
//
// Input channel s_axis: one transaction carries an opcode in tuser and the bus,
// level, fade length, mute flag and tick delta in tdata. Output channel m_axis:
// one transaction per changed bus, with the bus and applied Q2.14 volume in
// tdata and tlast on the final result caused by one input transaction.
// Set-volume, fade and mute transactions are latched in S_IDLE and S_EXEC
// loads their result into the output register; a fade with a nonzero length
// and a set-volume on a muted bus give no result. A tick transaction walks
// the buses in order: S_TSCAN skips a bus with no fade, a fade that reaches
// its target passes S_TCALC and S_TWRITE, and a fade step also waits in S_TDIV
// on the bit-serial divider shared by all buses. s_axis_tready stays low until
// the walk finishes. A full output register stalls the walk (or the single
// result) until m_axis_tready frees it, so nothing is dropped. The block takes
// the next input while a result still waits in the output register.
// Reset restores the default volumes, cancels all fades, unmutes every bus and
// empties the output register.
`include "multi_bus_volume_fader_macros.svh"

module multi_bus_volume_fader
  import mbvf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] bus, [18:3] level, [34:19] fade_ticks, [35] mute_on,
  // [43:36] delta_ticks, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] out_bus, [18:3] applied_volume, [23:19] zero
  output logic [23:0] m_axis_tdata,
  // last
  output logic        m_axis_tlast
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TSCAN = 3'd2;
  localparam logic [2:0] S_TCALC = 3'd3;
  localparam logic [2:0] S_TDIV  = 3'd4;
  localparam logic [2:0] S_TWRITE = 3'd5;

  logic [2:0] state;

  // per-bus state
  logic [VOL_W-1:0] bus_volume   [NUM_BUSES];
  logic [VOL_W-1:0] bus_target   [NUM_BUSES];
  logic [LEN_W-1:0] fade_length  [NUM_BUSES];
  logic [ELA_W-1:0] fade_elapsed [NUM_BUSES];
  logic [NUM_BUSES-1:0] bus_muted;

  // latched transaction
  logic [1:0]       op;
  logic [BUS_W-1:0] bus;
  logic [VOL_W-1:0] level;
  logic [LEN_W-1:0] fade_ticks;
  logic             mute_on;
  logic [DT_W-1:0]  dt;

  // tick walk
  logic [SCAN_W-1:0]    scan_idx;
  logic [NUM_BUSES-1:0] emit_mask;
  logic [NUM_BUSES-1:0] tick_mask;
  logic [NUM_BUSES-1:0] later_mask;
  logic [ELA_W-1:0]     ela_new;
  logic [LEN_W-1:0]     len_new;
  logic [VOL_W-1:0]     vol_new;
  logic                 step_neg;

  // selected entry
  logic [IDX_W-1:0] rd_addr;
  logic [VOL_W-1:0] rd_vol;
  logic [VOL_W-1:0] rd_tgt;
  logic [LEN_W-1:0] rd_len;
  logic [ELA_W-1:0] rd_ela;
  logic             rd_muted;
  logic             bus_valid;
  logic             tick_state;

  // fade step arithmetic
  logic signed [VOL_W:0]        diff;
  logic signed [VOL_W+DT_W:0]   prod;
  logic [VOL_W+DT_W:0]          prod_mag;
  logic [DIVS_W-1:0]            div_den;
  logic                         div_start;
  logic [DIVD_W-1:0]            div_quo;
  div_stat_t                    div_stat;
  logic signed [VOL_W+1:0]      step;
  logic signed [VOL_W+1:0]      vol_sum;

  // output register control
  logic             out_free;
  logic             out_load;
  logic [BUS_W-1:0] out_bus;
  logic [VOL_W-1:0] out_vol;
  logic             out_last;
  logic [VOL_W-1:0] clamped;
  logic             in_accept;

  logic signed [VOL_W:0] chk_d_new;
  logic signed [VOL_W:0] chk_d_tgt;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign tick_state    = (state == S_TSCAN) || (state == S_TCALC) ||
                         (state == S_TDIV) || (state == S_TWRITE);
  assign rd_addr       = tick_state ? IDX_W'(scan_idx) : IDX_W'(bus);
  assign rd_vol        = bus_volume[rd_addr];
  assign rd_tgt        = bus_target[rd_addr];
  assign rd_len        = fade_length[rd_addr];
  assign rd_ela        = fade_elapsed[rd_addr];
  assign rd_muted      = bus_muted[rd_addr];
  assign bus_valid     = 32'(bus) < NUM_BUSES;
  assign clamped       = level[VOL_W-1] ? '0 : level;

  assign diff     = $signed({rd_tgt[VOL_W-1], rd_tgt}) - $signed({rd_vol[VOL_W-1], rd_vol});
  assign prod     = diff * $signed({1'b0, dt});
  assign prod_mag = prod[VOL_W+DT_W] ? (VOL_W+DT_W+1)'(-prod) : prod;
  assign div_den  = DIVS_W'(rd_len - ela_new[LEN_W-1:0]) + DIVS_W'(dt);
  assign div_start = (state == S_TCALC) && (ela_new < {1'b0, rd_len});

  assign step    = step_neg ? -$signed({1'b0, div_quo[VOL_W:0]})
                            : $signed({1'b0, div_quo[VOL_W:0]});
  assign vol_sum = $signed({{2{rd_vol[VOL_W-1]}}, rd_vol}) + step;

  mbvf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIVD_W'(prod_mag)),
    .divisor  (div_den),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    for (int i = 0; i < NUM_BUSES; i++) begin
      tick_mask[i]  = (fade_length[i] != '0) && !bus_muted[i];
      later_mask[i] = emit_mask[i] && (SCAN_W'(i) > scan_idx);
    end
  end

  // output selection for the cycle that loads the result register
  always_comb begin
    out_load = 1'b0;
    out_bus  = bus;
    out_vol  = clamped;
    out_last = 1'b1;
    if (state == S_EXEC && bus_valid && out_free) begin
      if (op == OP_SET_MUTE) begin
        out_load = 1'b1;
        out_vol  = mute_on ? '0 : rd_vol;
      end else if (!(op == OP_FADE && fade_ticks != '0)) begin
        out_load = !rd_muted;
      end
    end else if (state == S_TWRITE && !rd_muted && out_free) begin
      out_load = 1'b1;
      out_bus  = BUS_W'(scan_idx);
      out_vol  = vol_new;
      out_last = (later_mask == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_axis_tdata <= {5'd0, out_vol, out_bus};
      m_axis_tlast <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      emit_mask <= '0;
      bus_muted <= '0;
      for (int i = 0; i < NUM_BUSES; i++) begin
        bus_volume[i]   <= default_volume(i);
        bus_target[i]   <= default_volume(i);
        fade_length[i]  <= '0;
        fade_elapsed[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            op         <= s_axis_tuser;
            bus        <= s_axis_tdata[2:0];
            level      <= s_axis_tdata[18:3];
            fade_ticks <= s_axis_tdata[34:19];
            mute_on    <= s_axis_tdata[35];
            dt         <= s_axis_tdata[43:36];
            scan_idx   <= '0;
            emit_mask  <= tick_mask;
            state      <= (s_axis_tuser == OP_TICK) ? S_TSCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          if (!bus_valid) begin
            state <= S_IDLE;
          end else if (op == OP_SET_MUTE) begin
            if (out_free) begin
              bus_muted[rd_addr] <= mute_on;
              state              <= S_IDLE;
            end
          end else if (op == OP_FADE && fade_ticks != '0) begin
            bus_target[rd_addr]   <= level;
            fade_length[rd_addr]  <= fade_ticks;
            fade_elapsed[rd_addr] <= '0;
            state                 <= S_IDLE;
          end else if (rd_muted || out_free) begin
            bus_volume[rd_addr]  <= clamped;
            bus_target[rd_addr]  <= clamped;
            fade_length[rd_addr] <= '0;
            state                <= S_IDLE;
          end
        end
        S_TSCAN: begin
          if (32'(scan_idx) == NUM_BUSES) begin
            state <= S_IDLE;
          end else if (rd_len == '0) begin
            scan_idx <= scan_idx + 1'b1;
          end else begin
            ela_new <= rd_ela + ELA_W'(dt);
            state   <= S_TCALC;
          end
        end
        S_TCALC: begin
          if (ela_new >= {1'b0, rd_len}) begin
            // time used up: jump to the target and end the fade
            vol_new <= rd_tgt;
            len_new <= '0;
            state   <= S_TWRITE;
          end else begin
            step_neg <= prod[VOL_W+DT_W];
            len_new  <= rd_len;
            state    <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_stat.done) begin
            vol_new <= vol_sum[VOL_W-1:0];
            state   <= S_TWRITE;
          end
        end
        S_TWRITE: begin
          if (rd_muted || out_free) begin
            bus_volume[rd_addr]   <= vol_new;
            fade_length[rd_addr]  <= len_new;
            fade_elapsed[rd_addr] <= ela_new;
            scan_idx              <= scan_idx + 1'b1;
            state                 <= S_TSCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign chk_d_new = $signed({vol_new[VOL_W-1], vol_new}) - $signed({rd_vol[VOL_W-1], rd_vol});
  assign chk_d_tgt = diff;

  `MBVF_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `MBVF_ASSERT_NOW(a_out_no_overwrite, out_load, !m_axis_tvalid || m_axis_tready, "result overwritten before taken")
  `MBVF_ASSERT_NOW(a_step_toward_target, state == S_TWRITE, chk_d_new == '0 || chk_d_new[VOL_W] == chk_d_tgt[VOL_W], "fade stepped away from target")

endmodule

// ===== design/mbvf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`include "multi_bus_volume_fader_macros.svh"

module mbvf_div
  import mbvf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output div_stat_t         stat
);

  logic [DIVS_W-1:0]    rem;
  logic [DIVS_W-1:0]    den;
  logic [DIVD_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIVS_W:0]      shifted;
  logic [DIVS_W:0]      trial;

  assign shifted  = {rem, quo[DIVD_W-1]};
  assign trial    = shifted - {1'b0, den};
  assign quotient = quo;
  assign stat     = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        den  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[DIVS_W]) begin
          rem <= trial[DIVS_W-1:0];
          quo <= {quo[DIVD_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIVS_W-1:0];
          quo <= {quo[DIVD_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `MBVF_ASSERT_NOW(a_div_rem_below_den, done, rem < den, "divider remainder not below divisor")
  `MBVF_ASSERT_NEXT(a_div_done_pulse, done && !start, !done && !busy, "divider done not a single pulse")
  `MBVF_ASSERT_NEXT(a_div_start_busy, start, busy && cnt == '0, "divider did not start")

endmodule
